// ===== src/hrrn_pkg.sv =====
`default_nettype none

package hrrn_pkg;

	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;
	localparam int ID_W    = 8;
	localparam int VAL_W   = 16;
	localparam int RATIO_W = VAL_W + 1;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
	localparam logic [OP_W-1:0] OP_SELECT = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
	localparam logic [STAT_W-1:0] STAT_ZERO  = 2'd3;

	localparam logic [VAL_W-1:0] WAIT_MAX = '1;

	typedef struct packed {
		logic [OP_W-1:0]  op;
		logic [ID_W-1:0]  proc_id;
		logic [VAL_W-1:0] burst_len;
	} hrrn_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [ID_W-1:0]    chosen_id;
		logic [RATIO_W-1:0] chosen_ratio;
	} hrrn_rsp_t;

	// write strobes from the sequencer to the slot store
	typedef struct packed {
		logic insert_wr;
		logic wait_wr;
		logic clear;
	} hrrn_store_cmd_t;

endpackage

`default_nettype wire

// ===== src/hrrn_stream_if.sv =====
`default_nettype none

interface hrrn_stream_if #(
	parameter type data_t = logic
);
	logic  valid;
	logic  ready;
	data_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/hrrn_divider.sv =====
`default_nettype none

module hrrn_divider
	import hrrn_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] dividend,
	input  logic [VAL_W-1:0] divisor,
	output logic             done,
	output logic [VAL_W-1:0] quotient
);

	localparam int STEP_W = $clog2(VAL_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VAL_W - 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [VAL_W-1:0]  rem_q;
	logic [VAL_W-1:0]  quo_q;
	logic [VAL_W-1:0]  div_q;

	logic [VAL_W:0] trial;
	logic [VAL_W:0] diff;
	logic           ge;

	// restoring division, one quotient bit a cycle
	assign trial = {rem_q, quo_q[VAL_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				rem_q  <= '0;
				quo_q  <= dividend;
				div_q  <= divisor;
			end else if (busy_q) begin
				rem_q  <= ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
				quo_q  <= {quo_q[VAL_W-2:0], ge};
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(VAL_W + 1) done)
		else $error("divider did not finish on time");

endmodule

`default_nettype wire

// ===== src/hrrn_slot_store.sv =====
`default_nettype none

module hrrn_slot_store
	import hrrn_pkg::*;
#(
	parameter int TABLE_DEPTH = 16,
	localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  hrrn_store_cmd_t        cmd,
	input  logic [IDX_W-1:0]       addr,
	input  logic [ID_W-1:0]        wr_id,
	input  logic [VAL_W-1:0]       wr_service,
	input  logic [VAL_W-1:0]       wr_wait,
	output logic [TABLE_DEPTH-1:0] valid_vec,
	output logic [ID_W-1:0]        rd_id,
	output logic [VAL_W-1:0]       rd_service,
	output logic [VAL_W-1:0]       rd_wait
);

	logic [ID_W-1:0]  id_mem   [TABLE_DEPTH];
	logic [VAL_W-1:0] svc_mem  [TABLE_DEPTH];
	logic [VAL_W-1:0] wait_mem [TABLE_DEPTH];

	logic [TABLE_DEPTH-1:0] valid_q;
	logic [ID_W-1:0]        rd_id_q;
	logic [VAL_W-1:0]       rd_service_q;
	logic [VAL_W-1:0]       rd_wait_q;

	always_ff @(posedge clk) begin
		if (cmd.insert_wr) begin
			id_mem[addr]  <= wr_id;
			svc_mem[addr] <= wr_service;
		end
		if (cmd.insert_wr || cmd.wait_wr) begin
			wait_mem[addr] <= wr_wait;
		end
		rd_id_q      <= id_mem[addr];
		rd_service_q <= svc_mem[addr];
		rd_wait_q    <= wait_mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.insert_wr) begin
			valid_q[addr] <= 1'b1;
		end else if (cmd.clear) begin
			valid_q[addr] <= 1'b0;
		end
	end

	assign valid_vec  = valid_q;
	assign rd_id      = rd_id_q;
	assign rd_service = rd_service_q;
	assign rd_wait    = rd_wait_q;

endmodule

`default_nettype wire

// ===== src/hrrn_process_selector_unit.sv =====
// Highest-response-ratio-next selector over TABLE_DEPTH slots. Insert takes the lowest free
// slot, tick ages every occupied slot by one (saturating), select returns and frees the slot
// with the highest (wait + service) / service, ties to the lowest slot. One request is
// processed at a time and every request gives exactly one response. Slots are visited in
// order from the lowest; the ratio comes from a shared bit-serial divider. A zero service
// time on insert or an unused op is answered without a scan. The next request can be taken
// while a response is still waiting on rsp.
`default_nettype none

module hrrn_process_selector_unit
	import hrrn_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	hrrn_stream_if.sink   req,
	hrrn_stream_if.source rsp
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_EVAL = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_OUT  = 3'd4;

	logic [2:0]         state_q;
	logic [OP_W-1:0]    op_q;
	logic [ID_W-1:0]    id_q;
	logic [VAL_W-1:0]   svc_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               found_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [ID_W-1:0]    best_id_q;
	logic [RATIO_W-1:0] best_ratio_q;
	logic [ID_W-1:0]    cur_id_q;
	logic [STAT_W-1:0]  res_status_q;
	logic [ID_W-1:0]    res_id_q;
	logic [RATIO_W-1:0] res_ratio_q;
	logic               out_valid_q;
	hrrn_rsp_t          out_data_q;

	hrrn_req_t              req_data;
	hrrn_store_cmd_t        store_cmd;
	logic [IDX_W-1:0]       store_addr;
	logic [VAL_W-1:0]       wr_wait;
	logic [TABLE_DEPTH-1:0] valid_vec;
	logic [ID_W-1:0]        rd_id;
	logic [VAL_W-1:0]       rd_service;
	logic [VAL_W-1:0]       rd_wait;
	logic                   div_start;
	logic                   div_done;
	logic [VAL_W-1:0]       div_quo;

	logic [IDX_W-1:0]   cnt_idx;
	logic               slot_v;
	logic               scan_end;
	logic [RATIO_W-1:0] ratio_cur;
	logic               out_load;

	assign req_data  = req.data;
	assign cnt_idx   = cnt_q[IDX_W-1:0];
	assign slot_v    = valid_vec[cnt_idx];
	assign scan_end  = cnt_q == CNT_END;
	assign ratio_cur = {1'b0, div_quo} + RATIO_W'(1);
	assign out_load  = state_q == S_OUT && (!out_valid_q || rsp.ready);

	hrrn_slot_store #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_store (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (store_cmd),
		.addr       (store_addr),
		.wr_id      (id_q),
		.wr_service (svc_q),
		.wr_wait    (wr_wait),
		.valid_vec  (valid_vec),
		.rd_id      (rd_id),
		.rd_service (rd_service),
		.rd_wait    (rd_wait)
	);

	hrrn_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (rd_wait),
		.divisor  (rd_service),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		store_cmd  = '0;
		store_addr = cnt_idx;
		wr_wait    = '0;
		div_start  = 1'b0;
		case (state_q)
			S_SCAN: begin
				if (scan_end) begin
					if (op_q == OP_SELECT && found_q) begin
						store_cmd.clear = 1'b1;
						store_addr      = best_idx_q;
					end
				end else if (op_q == OP_INSERT && !slot_v) begin
					store_cmd.insert_wr = 1'b1;
				end
			end
			S_EVAL: begin
				if (op_q == OP_TICK) begin
					store_cmd.wait_wr = 1'b1;
					wr_wait = (rd_wait == WAIT_MAX) ? rd_wait : rd_wait + VAL_W'(1);
				end else begin
					div_start = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			op_q         <= OP_INSERT;
			id_q         <= '0;
			svc_q        <= '0;
			cnt_q        <= '0;
			found_q      <= 1'b0;
			best_idx_q   <= '0;
			best_id_q    <= '0;
			best_ratio_q <= '0;
			cur_id_q     <= '0;
			res_status_q <= STAT_OK;
			res_id_q     <= '0;
			res_ratio_q  <= '0;
			out_valid_q  <= 1'b0;
			out_data_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q         <= req_data.op;
						id_q         <= req_data.proc_id;
						svc_q        <= req_data.burst_len;
						cnt_q        <= '0;
						found_q      <= 1'b0;
						res_status_q <= STAT_OK;
						res_id_q     <= '0;
						res_ratio_q  <= '0;
						if (req_data.op == OP_INSERT && req_data.burst_len == '0) begin
							res_status_q <= STAT_ZERO;
							state_q      <= S_OUT;
						end else if (req_data.op == OP_INSERT || req_data.op == OP_TICK ||
						             req_data.op == OP_SELECT) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_SCAN: begin
					if (scan_end) begin
						if (op_q == OP_INSERT) begin
							res_status_q <= STAT_FULL;
						end else if (op_q == OP_SELECT) begin
							if (found_q) begin
								res_id_q    <= best_id_q;
								res_ratio_q <= best_ratio_q;
							end else begin
								res_status_q <= STAT_EMPTY;
							end
						end
						state_q <= S_OUT;
					end else if (op_q == OP_INSERT) begin
						if (!slot_v) begin
							state_q <= S_OUT;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end else if (slot_v) begin
						state_q <= S_EVAL;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_EVAL: begin
					if (op_q == OP_TICK) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_SCAN;
					end else begin
						cur_id_q <= rd_id;
						state_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (!found_q || ratio_cur > best_ratio_q) begin
							found_q      <= 1'b1;
							best_idx_q   <= cnt_idx;
							best_id_q    <= cur_id_q;
							best_ratio_q <= ratio_cur;
						end
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_SCAN;
					end
				end
				S_OUT: begin
					if (out_load) begin
						out_data_q.status       <= res_status_q;
						out_data_q.chosen_id    <= res_id_q;
						out_data_q.chosen_ratio <= res_ratio_q;
						state_q                 <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready = state_q == S_IDLE;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	a_insert_free: assert property (@(posedge clk) disable iff (!arst_n)
		store_cmd.insert_wr |-> !valid_vec[store_addr])
		else $error("insert into an occupied slot");

	a_clear_used: assert property (@(posedge clk) disable iff (!arst_n)
		store_cmd.clear |-> valid_vec[store_addr])
		else $error("select frees an empty slot");

	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q.status != STAT_OK) |->
		(out_data_q.chosen_id == '0 && out_data_q.chosen_ratio == '0))
		else $error("failed request carries a chosen entry");

	a_div_in_select: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> (op_q == OP_SELECT && rd_service != '0))
		else $error("divider started outside select or on zero service");

endmodule

`default_nettype wire

// ===== sim/hrrn_process_selector_checker.sv =====
`timescale 1ns / 100ps

module hrrn_process_selector_checker
	import hrrn_pkg::*;
#(
	parameter int TABLE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_ready,
	input  hrrn_req_t req_data,
	input  logic      rsp_valid,
	input  logic      rsp_ready,
	input  hrrn_rsp_t rsp_data,
	output int        fail_count,
	output int        open_count
);

	bit               slot_busy [TABLE_DEPTH];
	logic [ID_W-1:0]  slot_pid [TABLE_DEPTH];
	logic [VAL_W-1:0] slot_svc [TABLE_DEPTH];
	logic [VAL_W-1:0] slot_age [TABLE_DEPTH];
	hrrn_rsp_t        due_answers [$];
	hrrn_rsp_t        want;
	int               errs;

	function automatic hrrn_rsp_t schedule_step(hrrn_req_t r);
		hrrn_rsp_t   a;
		int          pick;
		int unsigned ratio;
		int unsigned top_ratio;
		a = '0;
		pick = -1;
		top_ratio = 0;
		case (r.op)
		OP_INSERT: begin
			if (r.burst_len == '0) begin
				a.status = STAT_ZERO;
			end else begin
				for (int k = 0; k < TABLE_DEPTH; k++)
					if (!slot_busy[k] && pick < 0)
						pick = k;
				if (pick < 0) begin
					a.status = STAT_FULL;
				end else begin
					slot_busy[pick] = 1'b1;
					slot_pid[pick] = r.proc_id;
					slot_svc[pick] = r.burst_len;
					slot_age[pick] = '0;
					a.status = STAT_OK;
				end
			end
		end
		OP_TICK: begin
			for (int k = 0; k < TABLE_DEPTH; k++)
				if (slot_busy[k] && slot_age[k] != WAIT_MAX)
					slot_age[k] = slot_age[k] + 1'b1;
		end
		OP_SELECT: begin
			for (int k = 0; k < TABLE_DEPTH; k++) begin
				if (slot_busy[k]) begin
					ratio = slot_age[k];
					ratio = (ratio + slot_svc[k]) / slot_svc[k];
					if (pick < 0 || ratio > top_ratio) begin
						pick = k;
						top_ratio = ratio;
					end
				end
			end
			if (pick < 0) begin
				a.status = STAT_EMPTY;
			end else begin
				a.status = STAT_OK;
				a.chosen_id = slot_pid[pick];
				a.chosen_ratio = top_ratio[RATIO_W-1:0];
				slot_busy[pick] = 1'b0;
			end
		end
		default: begin
			a.status = STAT_OK;
		end
		endcase
		return a;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_DEPTH; k++)
				slot_busy[k] = 1'b0;
			due_answers.delete();
			open_count <= 0;
		end else begin
			// response side first: a beat out never belongs to a request taken on the same edge
			if (rsp_valid && rsp_ready) begin
				if (due_answers.size() == 0) begin
					errs++;
					$display("%0t: unexpected response beat, expected none, got %h",
						$time, rsp_data);
				end else begin
					want = due_answers.pop_front();
					if (rsp_data.status !== want.status) begin
						errs++;
						$display("%0t: status expected %0d, got %0d",
							$time, want.status, rsp_data.status);
					end
					if (rsp_data.chosen_id !== want.chosen_id) begin
						errs++;
						$display("%0t: chosen_id expected %0d, got %0d",
							$time, want.chosen_id, rsp_data.chosen_id);
					end
					if (rsp_data.chosen_ratio !== want.chosen_ratio) begin
						errs++;
						$display("%0t: chosen_ratio expected %0d, got %0d",
							$time, want.chosen_ratio, rsp_data.chosen_ratio);
					end
				end
			end
			if (req_valid && req_ready)
				due_answers.push_back(schedule_step(req_data));
			open_count <= due_answers.size();
		end
		fail_count <= errs;
	end

endmodule

// ===== sim/hrrn_process_selector_unit_tb.sv =====
`timescale 1ns / 100ps

module hrrn_process_selector_unit_tb;
	import hrrn_pkg::*;

	localparam int DEPTH = 16;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_BEATS = 300;
	localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   steady = 1'b0;
	int   fail_count;
	int   open_count;
	int   quiet_cycles = 0;

	hrrn_stream_if #(.data_t(hrrn_req_t)) req_if ();
	hrrn_stream_if #(.data_t(hrrn_rsp_t)) rsp_if ();

	hrrn_process_selector_unit #(
		.TABLE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if),
		.rsp(rsp_if)
	);

	hrrn_process_selector_checker #(
		.TABLE_DEPTH(DEPTH)
	) ratio_check (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_if.valid),
		.req_ready(req_if.ready),
		.req_data(req_if.data),
		.rsp_valid(rsp_if.valid),
		.rsp_ready(rsp_if.ready),
		.rsp_data(rsp_if.data),
		.fail_count(fail_count),
		.open_count(open_count)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (!arst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 80);
	endfunction

	function automatic logic [VAL_W-1:0] pick_service();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return VAL_W'($urandom_range(1, 6));
		if (r < 85)
			return VAL_W'($urandom_range(7, 300));
		return VAL_W'($urandom_range(1, 65535));
	endfunction

	task automatic issue(input logic [OP_W-1:0] op, input logic [ID_W-1:0] pid,
			input logic [VAL_W-1:0] svc);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			req_if.data <= $bits(hrrn_req_t)'($urandom);
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data <= '{op: op, proc_id: pid, burst_len: svc};
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
	endtask

	task automatic drive_ready();
		int n;
		@(posedge clk);
		forever begin
			n = idle_len();
			if (n > 0) begin
				rsp_if.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			rsp_if.ready <= 1'b1;
			n = $urandom_range(1, 8);
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic random_beat(input bit filling);
		int r;
		logic [ID_W-1:0] pid;
		r = $urandom_range(0, 99);
		pid = ID_W'($urandom);
		if (r < 3)
			issue(OP_INSERT, pid, '0);
		else if (r < 6)
			issue(OP_SPARE, pid, VAL_W'($urandom));
		else if (r < (filling ? 56 : 31))
			issue(OP_INSERT, pid, pick_service());
		else if (r < (filling ? 86 : 61))
			issue(OP_TICK, pid, VAL_W'($urandom));
		else
			issue(OP_SELECT, pid, VAL_W'($urandom));
	endtask

	initial begin
		req_if.valid = 1'b0;
		req_if.data = '0;
		rsp_if.ready = 1'b0;
		fork
			drive_ready();
		join_none
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(OP_SELECT, 8'h5A, 16'h1234);
		issue(OP_INSERT, 8'hFF, '0);
		for (int k = 0; k < DEPTH; k++) begin
			if (k == 0)
				issue(OP_INSERT, 8'h00, 16'hFFFF);
			else if (k == 1 || k % 3 == 0)
				issue(OP_INSERT, ID_W'(k * 17), 16'd1);
			else
				issue(OP_INSERT, ID_W'(k * 17), VAL_W'(1 << k));
		end
		issue(OP_INSERT, 8'hAB, 16'd7);
		issue(OP_INSERT, 8'hCD, '0);
		issue(OP_SPARE, 8'hFF, 16'hFFFF);
		issue(OP_TICK, 8'h00, 16'h0000);
		issue(OP_SELECT, 8'h00, 16'h0000);
		issue(OP_SELECT, 8'hFF, 16'hFFFF);

		for (int p = 0; p < 6; p++) begin
			steady = (p == 3);
			for (int n = 0; n < PHASE_BEATS; n++)
				random_beat(p % 2 == 0);
		end
		steady = 1'b0;

		req_if.valid <= 1'b0;
		@(posedge clk);
		while (open_count != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
